@@ rtl/core/i2p_pkg.sv @@
// Shared types, character codes and classification functions of the infix to postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

  // Operator characters with a defined precedence.
  localparam logic [7:0] CH_MUL = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV = 8'h2F;  // '/'
  localparam logic [7:0] CH_MOD = 8'h25;  // '%'
  localparam logic [7:0] CH_ADD = 8'h2B;  // '+'
  localparam logic [7:0] CH_SUB = 8'h2D;  // '-'

  // Operand ranges.
  localparam logic [7:0] CH_DIG_LO = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_HI = 8'h39;  // '9'
  localparam logic [7:0] CH_UPR_LO = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPR_HI = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LWR_LO = 8'h61;  // 'a'
  localparam logic [7:0] CH_LWR_HI = 8'h7A;  // 'z'

  // Precedence ranks.
  localparam logic [1:0] RANK_NONE = 2'd0;
  localparam logic [1:0] RANK_ADD  = 2'd1;
  localparam logic [1:0] RANK_MUL  = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       expr_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expr_done;
    logic       overflow_seen;
  } result_t;

  // Classified character handed from front to back.
  typedef struct packed {
    logic [7:0] symbol;
    logic       operand;
    logic [1:0] rank;
    logic       last;
  } cmd_t;

  function automatic logic is_operand(logic [7:0] c);
    return (c >= CH_DIG_LO && c <= CH_DIG_HI) ||
           (c >= CH_UPR_LO && c <= CH_UPR_HI) ||
           (c >= CH_LWR_LO && c <= CH_LWR_HI);
  endfunction

  function automatic logic [1:0] rank_of(logic [7:0] c);
    logic [1:0] r;
    r = RANK_NONE;
    if (c == CH_MUL || c == CH_DIV || c == CH_MOD) begin
      r = RANK_MUL;
    end else if (c == CH_ADD || c == CH_SUB) begin
      r = RANK_ADD;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/i2p_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module i2p_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/i2p_front.sv @@
// Front end: accepts characters, classifies them and queues them for the stack engine.
`timescale 1ns / 1ps

module i2p_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i2p_pkg::item_t item_i,
  output logic          full_o,
  output logic          cmd_valid_o,
  output i2p_pkg::cmd_t cmd_o,
  input  logic          cmd_take_i
);

  i2p_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          wr_en, rd_en;
  i2p_pkg::cmd_t cmd_new;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  assign wr_en = push_i && !full_o;
  assign rd_en = cmd_take_i && cmd_valid_o;

  always_comb begin
    cmd_new.symbol  = item_i.symbol;
    cmd_new.operand = i2p_pkg::is_operand(item_i.symbol);
    cmd_new.rank    = i2p_pkg::rank_of(item_i.symbol);
    cmd_new.last    = item_i.expr_last;
  end

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

@@ rtl/core/i2p_back.sv @@
// Back end: operator stack sequencer that pops, pushes and flushes.
`timescale 1ns / 1ps

module i2p_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  i2p_pkg::cmd_t    cmd_i,
  output logic             cmd_take_o,
  output logic             res_valid_o,
  output i2p_pkg::result_t res_o,
  input  logic             res_full_i
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CntFull = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CntOne  = CW'(1);
  localparam logic [CW-1:0] CntTwo  = CW'(2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPND  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FLOAD = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          flag_q, flag_d;
  logic          pend_valid_q, pend_valid_d;
  logic [7:0]    pend_sym_q, pend_sym_d;
  logic [7:0]    top_q, top_d;
  logic [7:0]    sym_q, sym_d;
  logic [1:0]    rank_q, rank_d;
  logic          last_q, last_d;

  logic          ram_we;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [7:0]    ram_rdata;
  logic          pop_cond;
  logic          advance;

  // The top entry lives in top_q; the RAM keeps the entries below it.
  assign cnt_m1   = count_q - CntOne;
  assign cnt_m2   = count_q - CntTwo;
  assign pop_cond = (count_q != '0) && (i2p_pkg::rank_of(top_q) >= rank_q);

  i2p_ram #(
    .Width (8),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_m1[AW-1:0]),
    .wdata_i (top_q),
    .raddr_i (cnt_m2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    flag_d       = flag_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    top_d        = top_q;
    sym_d        = sym_q;
    rank_d       = rank_q;
    last_d       = last_q;
    cmd_take_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;
    ram_we       = 1'b0;
    advance      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          sym_d      = cmd_i.symbol;
          rank_d     = cmd_i.rank;
          last_d     = cmd_i.last;
          state_d    = cmd_i.operand ? S_OPND : S_SCAN;
        end
      end

      S_OPND: begin
        res_valid_o         = 1'b1;
        res_o.out_symbol    = sym_q;
        res_o.run_last      = !(last_q && (count_q != '0));
        res_o.expr_done     = last_q && (count_q == '0);
        res_o.overflow_seen = flag_q;
        if (!res_full_i) begin
          if (last_q && (count_q != '0)) begin
            state_d = S_FLUSH;
          end else begin
            if (last_q) begin
              flag_d = 1'b0;
            end
            state_d = S_IDLE;
          end
        end
      end

      S_SCAN: begin
        // A popped operator waits in the pending slot until we know
        // whether another result of this character follows it.
        res_valid_o         = pend_valid_q;
        res_o.out_symbol    = pend_sym_q;
        res_o.overflow_seen = flag_q;
        advance             = !pend_valid_q || !res_full_i;
        if (pop_cond) begin
          res_o.run_last = 1'b0;
          if (advance) begin
            pend_valid_d = 1'b1;
            pend_sym_d   = top_q;
            count_d      = cnt_m1;
            state_d      = S_LOAD;
          end
        end else begin
          res_o.run_last = !last_q;
          if (advance) begin
            pend_valid_d = 1'b0;
            if (count_q != CntFull) begin
              ram_we  = (count_q != '0);
              top_d   = sym_q;
              count_d = count_q + CntOne;
            end else begin
              flag_d = 1'b1;
            end
            state_d = last_q ? S_FLUSH : S_IDLE;
          end
        end
      end

      S_LOAD: begin
        if (count_q != '0) begin
          top_d = ram_rdata;
        end
        state_d = S_SCAN;
      end

      S_FLUSH: begin
        res_valid_o         = 1'b1;
        res_o.out_symbol    = top_q;
        res_o.run_last      = (count_q == CntOne);
        res_o.expr_done     = (count_q == CntOne);
        res_o.overflow_seen = flag_q;
        if (!res_full_i) begin
          count_d = cnt_m1;
          if (count_q == CntOne) begin
            flag_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            state_d = S_FLOAD;
          end
        end
      end

      S_FLOAD: begin
        top_d   = ram_rdata;
        state_d = S_FLUSH;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      flag_q       <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      flag_q       <= flag_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    top_q      <= top_d;
    sym_q      <= sym_d;
    rank_q     <= rank_d;
    last_q     <= last_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("stack count above depth");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.expr_done |-> res_o.run_last)
    else $error("expression end not on last result of item");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_full_i && res_o.expr_done |=> (count_q == '0) && !flag_q)
    else $error("stack or overflow flag not cleared at expression end");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("pending pop left over between characters");

endmodule

@@ rtl/core/i2p_outbuf.sv @@
// Two-entry result queue between the stack engine and the result port.
`timescale 1ns / 1ps

module i2p_outbuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  i2p_pkg::result_t res_i,
  output logic             res_full_o,
  output logic             empty_o,
  output i2p_pkg::result_t result_o,
  input  logic             pop_i
);

  i2p_pkg::result_t slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign result_o   = slot_q[rd_ptr_q];

  assign wr_en = res_valid_i && !res_full_o;
  assign rd_en = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

@@ rtl/core/infix_to_postfix_converter.sv @@
// Top level of the infix to postfix converter: front queue, stack engine, result queue.
`timescale 1ns / 1ps

// Channel   Direction  Transfer when        Payload
// input     in         push && !full        item_i   (symbol, expr_last)
// result    out        pop && !empty        result_o (out_symbol, run_last,
//                                                     expr_done, overflow_seen)
//
// Engine steps: an operand passes S_IDLE and S_OPND; an operator passes S_IDLE
// and S_SCAN, plus S_LOAD and S_SCAN again per popped operator; the flush at
// expression end passes S_FLUSH and S_FLOAD per stacked entry, with no S_FLOAD
// after the last. S_LOAD and S_FLOAD cover the registered read of the stack RAM.
// A two-deep input queue and a two-deep result queue decouple both ports
// from the engine, so push and pop stall independently.
// Reset (rst_ni low, async) empties both queues and the stack and clears
// the overflow flag; stack RAM contents are not cleared.

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  i2p_pkg::item_t   item_i,
  output logic             full,
  output logic             empty,
  output i2p_pkg::result_t result_o,
  input  logic             pop
);

  logic             cmd_valid;
  logic             cmd_take;
  i2p_pkg::cmd_t    cmd;
  logic             res_valid;
  logic             res_full;
  i2p_pkg::result_t res;

  // Front: classify the character (operand / operator rank) and queue it.
  i2p_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Back: operator stack with left-associative popping and final flush.
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // Result queue: holds finished postfix characters until popped.
  i2p_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_full_o  (res_full),
    .empty_o     (empty),
    .result_o    (result_o),
    .pop_i       (pop)
  );

endmodule

@@ verif/infix_to_postfix_converter_tb.sv @@
// Self-checking testbench for the infix to postfix converter, with a scoreboard class.
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

  localparam int          STACK_DEPTH = 16;
  localparam int          ITEM_TARGET = 430;  // random part stops here
  localparam int          END_SETTLE  = 40;   // settle margin for the longest flush
  localparam logic [7:0]  OP_CHARS [5] = '{i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
                                           i2p_pkg::CH_MOD, i2p_pkg::CH_ADD,
                                           i2p_pkg::CH_SUB};

  // Tracks the converter: own operator stack, own sticky overflow flag and
  // the postfix characters still owed on the result side, oldest first.
  class postfix_tracker;
    logic [7:0]       op_stack [];
    int               stack_used;
    bit               dropped;
    int               stack_cap;
    i2p_pkg::result_t owed_chars [$];
    int               mismatches;

    function new(int cap);
      stack_cap  = cap;
      op_stack   = new[cap];
      stack_used = 0;
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    static function bit is_alnum(logic [7:0] c);
      return (c >= i2p_pkg::CH_DIG_LO && c <= i2p_pkg::CH_DIG_HI) ||
             (c >= i2p_pkg::CH_UPR_LO && c <= i2p_pkg::CH_UPR_HI) ||
             (c >= i2p_pkg::CH_LWR_LO && c <= i2p_pkg::CH_LWR_HI);
    endfunction

    static function logic [1:0] prec(logic [7:0] c);
      if (c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV || c == i2p_pkg::CH_MOD) begin
        return i2p_pkg::RANK_MUL;
      end
      if (c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB) begin
        return i2p_pkg::RANK_ADD;
      end
      return i2p_pkg::RANK_NONE;
    endfunction

    // An input transfer: work out every postfix character it releases.
    function void take_char(i2p_pkg::item_t it);
      i2p_pkg::result_t run [$];
      i2p_pkg::result_t r;
      logic [1:0]       rk;
      if (is_alnum(it.symbol)) begin
        r            = '0;
        r.out_symbol = it.symbol;
        run.push_back(r);
      end else begin
        rk = prec(it.symbol);
        // pop while top ranks at or above: left-associative
        while (stack_used > 0 && prec(op_stack[stack_used-1]) >= rk) begin
          stack_used--;
          r            = '0;
          r.out_symbol = op_stack[stack_used];
          run.push_back(r);
        end
        if (stack_used < stack_cap) begin
          op_stack[stack_used] = it.symbol;
          stack_used++;
        end else begin
          dropped = 1'b1;  // full stack: operator lost, flag sticks
        end
      end
      if (it.expr_last) begin
        while (stack_used > 0) begin
          stack_used--;
          r            = '0;
          r.out_symbol = op_stack[stack_used];
          run.push_back(r);
        end
      end
      foreach (run[k]) begin
        run[k].overflow_seen = dropped;
        if (k == run.size() - 1) begin
          run[k].run_last  = 1'b1;
          run[k].expr_done = it.expr_last;
        end
        owed_chars.push_back(run[k]);
      end
      if (it.expr_last) begin
        dropped = 1'b0;
      end
    endfunction

    // A result transfer: compare against the oldest owed character.
    function void match_char(i2p_pkg::result_t got);
      i2p_pkg::result_t want;
      if (owed_chars.size() == 0) begin
        $error("unexpected result transfer: out_symbol %h", got.out_symbol);
        mismatches++;
        return;
      end
      want = owed_chars.pop_front();
      if (got.out_symbol !== want.out_symbol) begin
        $error("out_symbol: expected %h, actual %h", want.out_symbol, got.out_symbol);
        mismatches++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
        mismatches++;
      end
      if (got.expr_done !== want.expr_done) begin
        $error("expr_done: expected %b, actual %b", want.expr_done, got.expr_done);
        mismatches++;
      end
      if (got.overflow_seen !== want.overflow_seen) begin
        $error("overflow_seen: expected %b, actual %b", want.overflow_seen,
               got.overflow_seen);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  i2p_pkg::item_t   item_i;
  logic             full;
  logic             empty;
  i2p_pkg::result_t result_o;
  logic             pop;

  postfix_tracker tracker;
  int unsigned    src_gap_pct;   // chance per cycle that the sender holds off
  int unsigned    sink_gap_pct;  // chance per cycle that pop stays low
  int             chars_sent;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .item_i  (item_i),
    .full    (full),
    .empty   (empty),
    .result_o(result_o),
    .pop     (pop)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5ms;
    $display("infix_to_postfix_converter regression: fail");
    $finish;
  end

  // Result side: check every completed transfer, then pick pop for the next cycle.
  // Values read here are the pre-edge ones the block sampled too.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        tracker.match_char(result_o);
      end
      pop <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  function automatic i2p_pkg::item_t mk_item(logic [7:0] sym, logic last);
    i2p_pkg::item_t it;
    it.symbol    = sym;
    it.expr_last = last;
    return it;
  endfunction

  function automatic logic [7:0] rand_operand();
    int unsigned k;
    k = $urandom_range(61);
    if (k < 10) begin
      return 8'(i2p_pkg::CH_DIG_LO + k);
    end else if (k < 36) begin
      return 8'(i2p_pkg::CH_UPR_LO + (k - 10));
    end
    return 8'(i2p_pkg::CH_LWR_LO + (k - 36));
  endfunction

  // Mostly the five ranked operators; the rest any byte that is not alphanumeric.
  function automatic logic [7:0] rand_operator();
    logic [7:0] c;
    if ($urandom_range(9) < 7) begin
      return OP_CHARS[$urandom_range(4)];
    end
    do begin
      c = 8'($urandom_range(255));
    end while (postfix_tracker::is_alnum(c));
    return c;
  endfunction

  // Idle phases follow the transfer count: sender dense / receiver busy,
  // then swapped, then full rate both ways.
  function automatic void set_gaps();
    case (chars_sent * 3 / ITEM_TARGET)
      0: begin
        src_gap_pct  = 8;
        sink_gap_pct = 68;
      end
      1: begin
        src_gap_pct  = 68;
        sink_gap_pct = 8;
      end
      default: begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end
    endcase
  endfunction

  // push stays high across back-to-back transfers; it only drops during a gap.
  task automatic send_item(i2p_pkg::item_t it);
    while ($urandom_range(99) < src_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    tracker.take_char(it);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(mk_item(s[i], i == s.len() - 1));
    end
  endtask

  // Well-formed: operand (operator operand)*, last flag on the final operand.
  task automatic send_expression();
    int terms;
    terms = ($urandom_range(7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      send_item(mk_item(rand_operand(), t == terms - 1));
      if (t != terms - 1) begin
        send_item(mk_item(rand_operator(), 1'b0));
      end
    end
  endtask

  // Broken: operand/operator picked freely, may end on an operator.
  task automatic send_jumble();
    int len;
    len = $urandom_range(1, 8);
    for (int t = 0; t < len; t++) begin
      send_item(mk_item($urandom_range(1) ? rand_operand() : rand_operator(),
                        t == len - 1));
    end
  endtask

  initial begin
    int unsigned pick;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    item_i       = '0;
    chars_sent   = 0;
    src_gap_pct  = 8;
    sink_gap_pct = 68;
    tracker      = new(STACK_DEPTH);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: precedence, left-associative chains, every operator,
    // operand extremes, lowest-rank bytes 00/FF, an expression ending on an
    // operator, and lone operator / operand expressions.
    send_text("a+b*c-d");
    send_text("9-8-7");
    send_text("Z%A/z");
    send_item(mk_item(8'h00, 1'b0));
    send_item(mk_item(8'hFF, 1'b1));
    send_text("+");
    send_text("0*1+2");
    send_text("x");

    // Random: mostly well-formed expressions, some jumbles, some raw bytes.
    while (chars_sent < ITEM_TARGET) begin
      set_gaps();
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_expression();
      end else if (pick < 88) begin
        send_jumble();
      end else begin
        send_item(mk_item(8'($urandom_range(255)), $urandom_range(5) == 0));
      end
    end
    push <= 1'b0;

    // Drain: wait for every owed character, then a few flush times more.
    while (tracker.owed_chars.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (END_SETTLE) @(posedge clk_i);

    if (tracker.mismatches == 0 && tracker.owed_chars.size() == 0) begin
      $display("infix_to_postfix_converter regression: pass");
    end else begin
      $display("infix_to_postfix_converter regression: fail");
    end
    $finish;
  end

endmodule
